### rtl/core/fq2_pkg.sv
// package for the GF(p^2) arithmetic core: widths, micro-op codes, register names,
// control structs, the microcode table and the mode dispatch table
// no dependencies
package fq2_pkg;

   localparam int FIELD_BITS   = 64;
   localparam int DATA_BITS    = 64;
   localparam int EXP_BITS     = 64;
   localparam int MODE_BITS    = 4;
   localparam int OP_BITS      = 4;
   localparam int COND_BITS    = 3;
   localparam int REG_BITS     = 4;
   localparam int RF_DEPTH     = 16;
   localparam int PC_BITS      = 7;
   localparam int CNT_BITS     = $clog2(EXP_BITS + 1);
   localparam int BIT_CNT_BITS = $clog2(FIELD_BITS + 1);

   localparam logic [DATA_BITS-1:0] PRIME_RESET = 64'hFFFF_FFFF_FFFF_FFC5;

   typedef logic [FIELD_BITS-1:0] elem_type;

   localparam logic [MODE_BITS-1:0] MODE_ADD  = 4'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUB  = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_MUL  = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_SQR  = 4'd3;
   localparam logic [MODE_BITS-1:0] MODE_NEG  = 4'd4;
   localparam logic [MODE_BITS-1:0] MODE_MB   = 4'd5;
   localparam logic [MODE_BITS-1:0] MODE_ADDB = 4'd6;
   localparam logic [MODE_BITS-1:0] MODE_SUBB = 4'd7;
   localparam logic [MODE_BITS-1:0] MODE_INV  = 4'd8;
   localparam logic [MODE_BITS-1:0] MODE_POW  = 4'd9;

   localparam logic [OP_BITS-1:0] OP_NOP   = 4'd0;
   localparam logic [OP_BITS-1:0] OP_ADD   = 4'd1;
   localparam logic [OP_BITS-1:0] OP_SUB   = 4'd2;
   localparam logic [OP_BITS-1:0] OP_NEG   = 4'd3;
   localparam logic [OP_BITS-1:0] OP_COPY  = 4'd4;
   localparam logic [OP_BITS-1:0] OP_ONE   = 4'd5;
   localparam logic [OP_BITS-1:0] OP_ZERO  = 4'd6;
   localparam logic [OP_BITS-1:0] OP_MUL   = 4'd7;
   localparam logic [OP_BITS-1:0] OP_RED   = 4'd8;
   localparam logic [OP_BITS-1:0] OP_EXPE  = 4'd9;
   localparam logic [OP_BITS-1:0] OP_EXPM  = 4'd10;
   localparam logic [OP_BITS-1:0] OP_NORM  = 4'd11;
   localparam logic [OP_BITS-1:0] OP_SHIFT = 4'd12;
   localparam logic [OP_BITS-1:0] OP_FLAG  = 4'd13;
   localparam logic [OP_BITS-1:0] OP_DONE  = 4'd14;

   localparam logic [COND_BITS-1:0] C_NONE   = 3'd0;
   localparam logic [COND_BITS-1:0] C_ALWAYS = 3'd1;
   localparam logic [COND_BITS-1:0] C_SMALL  = 3'd2;
   localparam logic [COND_BITS-1:0] C_DISP   = 3'd3;
   localparam logic [COND_BITS-1:0] C_ZF     = 3'd4;
   localparam logic [COND_BITS-1:0] C_EXPZ   = 3'd5;
   localparam logic [COND_BITS-1:0] C_CNTZ   = 3'd6;
   localparam logic [COND_BITS-1:0] C_NBIT   = 3'd7;

   localparam logic [REG_BITS-1:0] R_AR = 4'd0;
   localparam logic [REG_BITS-1:0] R_AI = 4'd1;
   localparam logic [REG_BITS-1:0] R_BR = 4'd2;
   localparam logic [REG_BITS-1:0] R_BI = 4'd3;
   localparam logic [REG_BITS-1:0] R_XR = 4'd4;
   localparam logic [REG_BITS-1:0] R_XI = 4'd5;
   localparam logic [REG_BITS-1:0] R_T0 = 4'd6;
   localparam logic [REG_BITS-1:0] R_T1 = 4'd7;
   localparam logic [REG_BITS-1:0] R_T2 = 4'd8;
   localparam logic [REG_BITS-1:0] R_T3 = 4'd9;

   localparam logic [PC_BITS-1:0] L_ADD   = 7'd6;
   localparam logic [PC_BITS-1:0] L_SUB   = 7'd8;
   localparam logic [PC_BITS-1:0] L_MUL   = 7'd10;
   localparam logic [PC_BITS-1:0] L_SQR   = 7'd20;
   localparam logic [PC_BITS-1:0] L_NEG   = 7'd27;
   localparam logic [PC_BITS-1:0] L_MB    = 7'd29;
   localparam logic [PC_BITS-1:0] L_ADDB  = 7'd31;
   localparam logic [PC_BITS-1:0] L_SUBB  = 7'd35;
   localparam logic [PC_BITS-1:0] L_INV   = 7'd39;
   localparam logic [PC_BITS-1:0] L_ILOOP = 7'd47;
   localparam logic [PC_BITS-1:0] L_ISKIP = 7'd51;
   localparam logic [PC_BITS-1:0] L_INV1  = 7'd52;
   localparam logic [PC_BITS-1:0] L_INVF  = 7'd53;
   localparam logic [PC_BITS-1:0] L_FLAG  = 7'd56;
   localparam logic [PC_BITS-1:0] L_CLR   = 7'd57;
   localparam logic [PC_BITS-1:0] L_POW   = 7'd59;
   localparam logic [PC_BITS-1:0] L_PLOOP = 7'd64;
   localparam logic [PC_BITS-1:0] L_PSKIP = 7'd79;
   localparam logic [PC_BITS-1:0] L_POW1  = 7'd80;
   localparam logic [PC_BITS-1:0] L_DONE  = 7'd82;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [REG_BITS-1:0]  dst;
      logic [REG_BITS-1:0]  sa;
      logic [REG_BITS-1:0]  sb;
      logic [COND_BITS-1:0] cond;
      logic [PC_BITS-1:0]   tgt;
   } ucode_type;

   typedef struct packed {
      logic                dp_start;
      logic [OP_BITS-1:0]  dp_op;
      logic [REG_BITS-1:0] rd_addr_a;
      logic [REG_BITS-1:0] rd_addr_b;
      logic                wr_en;
      logic [REG_BITS-1:0] wr_addr;
   } seq_ctl_type;

   typedef struct packed {
      logic done;
      logic zero;
   } dp_stat_type;

   function automatic ucode_type mk(input logic [OP_BITS-1:0] op,
                                    input logic [REG_BITS-1:0] dst,
                                    input logic [REG_BITS-1:0] sa,
                                    input logic [REG_BITS-1:0] sb,
                                    input logic [COND_BITS-1:0] cond,
                                    input logic [PC_BITS-1:0] tgt);
      ucode_type w;
      w.op   = op;
      w.dst  = dst;
      w.sa   = sa;
      w.sb   = sb;
      w.cond = cond;
      w.tgt  = tgt;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      unique case (pc)
         // prologue: small modulus check, operand reduction, mode dispatch
         7'd0:  w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_SMALL,  L_FLAG);
         7'd1:  w = mk(OP_RED,   R_AR, R_AR, R_AR, C_NONE,   L_DONE);
         7'd2:  w = mk(OP_RED,   R_AI, R_AI, R_AI, C_NONE,   L_DONE);
         7'd3:  w = mk(OP_RED,   R_BR, R_BR, R_BR, C_NONE,   L_DONE);
         7'd4:  w = mk(OP_RED,   R_BI, R_BI, R_BI, C_NONE,   L_DONE);
         7'd5:  w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_DISP,   L_DONE);
         // add, subtract
         7'd6:  w = mk(OP_ADD,   R_XR, R_AR, R_BR, C_NONE,   L_DONE);
         7'd7:  w = mk(OP_ADD,   R_XI, R_AI, R_BI, C_ALWAYS, L_DONE);
         7'd8:  w = mk(OP_SUB,   R_XR, R_AR, R_BR, C_NONE,   L_DONE);
         7'd9:  w = mk(OP_SUB,   R_XI, R_AI, R_BI, C_ALWAYS, L_DONE);
         // karatsuba multiply x = a * x
         7'd10: w = mk(OP_COPY,  R_XR, R_BR, R_BR, C_NONE,   L_DONE);
         7'd11: w = mk(OP_COPY,  R_XI, R_BI, R_BI, C_NONE,   L_DONE);
         7'd12: w = mk(OP_MUL,   R_T0, R_AR, R_XR, C_NONE,   L_DONE);
         7'd13: w = mk(OP_MUL,   R_T1, R_AI, R_XI, C_NONE,   L_DONE);
         7'd14: w = mk(OP_ADD,   R_T2, R_AR, R_AI, C_NONE,   L_DONE);
         7'd15: w = mk(OP_ADD,   R_T3, R_XR, R_XI, C_NONE,   L_DONE);
         7'd16: w = mk(OP_MUL,   R_T2, R_T2, R_T3, C_NONE,   L_DONE);
         7'd17: w = mk(OP_SUB,   R_XR, R_T0, R_T1, C_NONE,   L_DONE);
         7'd18: w = mk(OP_SUB,   R_T2, R_T2, R_T0, C_NONE,   L_DONE);
         7'd19: w = mk(OP_SUB,   R_XI, R_T2, R_T1, C_ALWAYS, L_DONE);
         // square
         7'd20: w = mk(OP_COPY,  R_XR, R_AR, R_AR, C_NONE,   L_DONE);
         7'd21: w = mk(OP_COPY,  R_XI, R_AI, R_AI, C_NONE,   L_DONE);
         7'd22: w = mk(OP_ADD,   R_T0, R_XR, R_XI, C_NONE,   L_DONE);
         7'd23: w = mk(OP_SUB,   R_T1, R_XR, R_XI, C_NONE,   L_DONE);
         7'd24: w = mk(OP_MUL,   R_T2, R_XR, R_XI, C_NONE,   L_DONE);
         7'd25: w = mk(OP_ADD,   R_XI, R_T2, R_T2, C_NONE,   L_DONE);
         7'd26: w = mk(OP_MUL,   R_XR, R_T0, R_T1, C_ALWAYS, L_DONE);
         // negate, times (1+i), plus and minus b(1+i)
         7'd27: w = mk(OP_NEG,   R_XR, R_AR, R_AR, C_NONE,   L_DONE);
         7'd28: w = mk(OP_NEG,   R_XI, R_AI, R_AI, C_ALWAYS, L_DONE);
         7'd29: w = mk(OP_SUB,   R_XR, R_AR, R_AI, C_NONE,   L_DONE);
         7'd30: w = mk(OP_ADD,   R_XI, R_AR, R_AI, C_ALWAYS, L_DONE);
         7'd31: w = mk(OP_SUB,   R_T0, R_BR, R_BI, C_NONE,   L_DONE);
         7'd32: w = mk(OP_ADD,   R_T1, R_BR, R_BI, C_NONE,   L_DONE);
         7'd33: w = mk(OP_ADD,   R_XR, R_AR, R_T0, C_NONE,   L_DONE);
         7'd34: w = mk(OP_ADD,   R_XI, R_AI, R_T1, C_ALWAYS, L_DONE);
         7'd35: w = mk(OP_SUB,   R_T0, R_BR, R_BI, C_NONE,   L_DONE);
         7'd36: w = mk(OP_ADD,   R_T1, R_BR, R_BI, C_NONE,   L_DONE);
         7'd37: w = mk(OP_SUB,   R_XR, R_AR, R_T0, C_NONE,   L_DONE);
         7'd38: w = mk(OP_SUB,   R_XI, R_AI, R_T1, C_ALWAYS, L_DONE);
         // inverse: conjugate times norm^(p-2)
         7'd39: w = mk(OP_MUL,   R_T0, R_AR, R_AR, C_NONE,   L_DONE);
         7'd40: w = mk(OP_MUL,   R_T1, R_AI, R_AI, C_NONE,   L_DONE);
         7'd41: w = mk(OP_ADD,   R_T0, R_T0, R_T1, C_NONE,   L_DONE);
         7'd42: w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_ZF,     L_FLAG);
         7'd43: w = mk(OP_EXPM,  R_XR, R_XR, R_XR, C_NONE,   L_DONE);
         7'd44: w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_EXPZ,   L_INV1);
         7'd45: w = mk(OP_NORM,  R_XR, R_XR, R_XR, C_NONE,   L_DONE);
         7'd46: w = mk(OP_COPY,  R_T1, R_T0, R_T0, C_NONE,   L_DONE);
         7'd47: w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_CNTZ,   L_INVF);
         7'd48: w = mk(OP_MUL,   R_T1, R_T1, R_T1, C_NONE,   L_DONE);
         7'd49: w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_NBIT,   L_ISKIP);
         7'd50: w = mk(OP_MUL,   R_T1, R_T1, R_T0, C_NONE,   L_DONE);
         7'd51: w = mk(OP_SHIFT, R_XR, R_XR, R_XR, C_ALWAYS, L_ILOOP);
         7'd52: w = mk(OP_ONE,   R_T1, R_T1, R_T1, C_NONE,   L_DONE);
         7'd53: w = mk(OP_MUL,   R_XR, R_AR, R_T1, C_NONE,   L_DONE);
         7'd54: w = mk(OP_NEG,   R_T2, R_AI, R_AI, C_NONE,   L_DONE);
         7'd55: w = mk(OP_MUL,   R_XI, R_T2, R_T1, C_ALWAYS, L_DONE);
         // zero result, with flag when an inverse was asked
         7'd56: w = mk(OP_FLAG,  R_XR, R_XR, R_XR, C_NONE,   L_DONE);
         7'd57: w = mk(OP_ZERO,  R_XR, R_XR, R_XR, C_NONE,   L_DONE);
         7'd58: w = mk(OP_ZERO,  R_XI, R_XI, R_XI, C_ALWAYS, L_DONE);
         // left-to-right power
         7'd59: w = mk(OP_EXPE,  R_XR, R_XR, R_XR, C_NONE,   L_DONE);
         7'd60: w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_EXPZ,   L_POW1);
         7'd61: w = mk(OP_NORM,  R_XR, R_XR, R_XR, C_NONE,   L_DONE);
         7'd62: w = mk(OP_COPY,  R_XR, R_AR, R_AR, C_NONE,   L_DONE);
         7'd63: w = mk(OP_COPY,  R_XI, R_AI, R_AI, C_NONE,   L_DONE);
         7'd64: w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_CNTZ,   L_DONE);
         7'd65: w = mk(OP_ADD,   R_T0, R_XR, R_XI, C_NONE,   L_DONE);
         7'd66: w = mk(OP_SUB,   R_T1, R_XR, R_XI, C_NONE,   L_DONE);
         7'd67: w = mk(OP_MUL,   R_T2, R_XR, R_XI, C_NONE,   L_DONE);
         7'd68: w = mk(OP_ADD,   R_XI, R_T2, R_T2, C_NONE,   L_DONE);
         7'd69: w = mk(OP_MUL,   R_XR, R_T0, R_T1, C_NONE,   L_DONE);
         7'd70: w = mk(OP_NOP,   R_XR, R_XR, R_XR, C_NBIT,   L_PSKIP);
         7'd71: w = mk(OP_MUL,   R_T0, R_AR, R_XR, C_NONE,   L_DONE);
         7'd72: w = mk(OP_MUL,   R_T1, R_AI, R_XI, C_NONE,   L_DONE);
         7'd73: w = mk(OP_ADD,   R_T2, R_AR, R_AI, C_NONE,   L_DONE);
         7'd74: w = mk(OP_ADD,   R_T3, R_XR, R_XI, C_NONE,   L_DONE);
         7'd75: w = mk(OP_MUL,   R_T2, R_T2, R_T3, C_NONE,   L_DONE);
         7'd76: w = mk(OP_SUB,   R_XR, R_T0, R_T1, C_NONE,   L_DONE);
         7'd77: w = mk(OP_SUB,   R_T2, R_T2, R_T0, C_NONE,   L_DONE);
         7'd78: w = mk(OP_SUB,   R_XI, R_T2, R_T1, C_NONE,   L_DONE);
         7'd79: w = mk(OP_SHIFT, R_XR, R_XR, R_XR, C_ALWAYS, L_PLOOP);
         7'd80: w = mk(OP_ONE,   R_XR, R_XR, R_XR, C_NONE,   L_DONE);
         7'd81: w = mk(OP_ZERO,  R_XI, R_XI, R_XI, C_NONE,   L_DONE);
         7'd82: w = mk(OP_DONE,  R_XR, R_XR, R_XI, C_NONE,   L_DONE);
         default: w = mk(OP_DONE, R_XR, R_XR, R_XI, C_NONE,  L_DONE);
      endcase
      return w;
   endfunction

   function automatic logic [PC_BITS-1:0] dispatch(input logic [MODE_BITS-1:0] mode);
      logic [PC_BITS-1:0] t;
      unique case (mode)
         MODE_ADD:  t = L_ADD;
         MODE_SUB:  t = L_SUB;
         MODE_MUL:  t = L_MUL;
         MODE_SQR:  t = L_SQR;
         MODE_NEG:  t = L_NEG;
         MODE_MB:   t = L_MB;
         MODE_ADDB: t = L_ADDB;
         MODE_SUBB: t = L_SUBB;
         MODE_INV:  t = L_INV;
         MODE_POW:  t = L_POW;
         default:   t = L_CLR;
      endcase
      return t;
   endfunction

endpackage

### rtl/core/fq2_regfile.sv
// scratch register file of base field values, one write and two registered reads
// depends on fq2_pkg
module fq2_regfile (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [fq2_pkg::REG_BITS-1:0] wr_addr,
   input  fq2_pkg::elem_type            wr_data,
   input  logic [fq2_pkg::REG_BITS-1:0] rd_addr_a,
   input  logic [fq2_pkg::REG_BITS-1:0] rd_addr_b,
   output fq2_pkg::elem_type            rd_data_a,
   output fq2_pkg::elem_type            rd_data_b
);
   import fq2_pkg::*;

   elem_type mem [RF_DEPTH];
   elem_type rd_a_ff;
   elem_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/core/fq2_datapath.sv
// modular arithmetic unit: combinational add, subtract, negate and moves,
// bit-serial multiply and reduction, one bit per cycle
// depends on fq2_pkg
module fq2_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fq2_pkg::OP_BITS-1:0] op,
   input  fq2_pkg::elem_type           opa,
   input  fq2_pkg::elem_type           opb,
   input  fq2_pkg::elem_type           raw,
   input  fq2_pkg::elem_type           modulus,
   output fq2_pkg::elem_type           result,
   output fq2_pkg::dp_stat_type        stat
);
   import fq2_pkg::*;

   function automatic elem_type add_mod(input elem_type x, input elem_type y,
                                        input elem_type m);
      logic [FIELD_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[FIELD_BITS-1:0];
   endfunction

   function automatic elem_type sub_mod(input elem_type x, input elem_type y,
                                        input elem_type m);
      return (x >= y) ? (x - y) : ((m - y) + x);
   endfunction

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    red_ff,  red_in;
   logic [BIT_CNT_BITS-1:0] cnt_ff,  cnt_in;
   elem_type                acc_ff,  acc_in;
   elem_type                a_ff,    a_in;
   elem_type                b_ff,    b_in;

   logic [FIELD_BITS:0] dbl_sum;
   elem_type            dbl_mod;
   elem_type            step_val;
   elem_type            simple_val;

   always_comb begin
      dbl_sum = {acc_ff, red_ff & b_ff[FIELD_BITS-1]};
      if (dbl_sum >= {1'b0, modulus}) begin
         dbl_sum = dbl_sum - {1'b0, modulus};
      end
      dbl_mod  = dbl_sum[FIELD_BITS-1:0];
      step_val = (!red_ff && b_ff[FIELD_BITS-1]) ? add_mod(dbl_mod, a_ff, modulus)
                                                 : dbl_mod;
   end

   always_comb begin
      case (op)
         OP_ADD:  simple_val = add_mod(opa, opb, modulus);
         OP_SUB:  simple_val = sub_mod(opa, opb, modulus);
         OP_NEG:  simple_val = (opa == '0) ? '0 : (modulus - opa);
         OP_COPY: simple_val = opa;
         OP_ONE:  simple_val = elem_type'(1);
         default: simple_val = '0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      red_in  = red_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         case (op)
            OP_MUL, OP_RED: begin
               busy_in = 1'b1;
               red_in  = (op == OP_RED);
               cnt_in  = BIT_CNT_BITS'(FIELD_BITS);
               acc_in  = '0;
               a_in    = opa;
               b_in    = (op == OP_RED) ? raw : opb;
            end
            default: begin
               acc_in  = simple_val;
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         acc_in = step_val;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == BIT_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff <= red_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign result    = acc_ff;
   assign stat.done = done_ff;
   assign stat.zero = (acc_ff == '0);

endmodule

### rtl/core/fq2_sequencer.sv
// microcode sequencer: step counter, control table, jump conditions,
// exponent shifter and error flag
// depends on fq2_pkg
module fq2_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fq2_pkg::MODE_BITS-1:0] mode,
   input  logic [fq2_pkg::EXP_BITS-1:0]  exponent,
   input  fq2_pkg::elem_type             modulus,
   input  fq2_pkg::dp_stat_type          dp_stat,
   input  logic                          out_free,
   output fq2_pkg::seq_ctl_type          ctl,
   output logic                          idle,
   output logic                          finish,
   output logic                          flag
);
   import fq2_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_WAIT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [PC_BITS-1:0]  pc_ff,    pc_in;
   logic [EXP_BITS-1:0] exp_ff,   exp_in;
   logic [CNT_BITS-1:0] cnt_ff,   cnt_in;
   logic                zf_ff,    zf_in;
   logic                flag_ff,  flag_in;

   ucode_type          uw;
   logic               is_dp;
   logic               taken;
   logic               complete;
   logic [PC_BITS-1:0] next_pc;

   assign uw = ucode_rom(pc_ff);

   always_comb begin
      case (uw.op) inside
         [OP_ADD:OP_RED]: is_dp = 1'b1;
         default:         is_dp = 1'b0;
      endcase
   end

   always_comb begin
      unique case (uw.cond)
         C_NONE:   taken = 1'b0;
         C_ALWAYS: taken = 1'b1;
         C_SMALL:  taken = (modulus < elem_type'(2));
         C_DISP:   taken = 1'b1;
         C_ZF:     taken = zf_ff;
         C_EXPZ:   taken = (exp_ff == '0);
         C_CNTZ:   taken = (cnt_ff == '0);
         C_NBIT:   taken = !exp_ff[EXP_BITS-1];
         default:  taken = 1'b0;
      endcase
      if (uw.cond == C_DISP) begin
         next_pc = dispatch(mode);
      end else if (taken) begin
         next_pc = uw.tgt;
      end else begin
         next_pc = pc_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      zf_in    = zf_ff;
      flag_in  = flag_ff;
      complete = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pc_in    = '0;
               flag_in  = 1'b0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (is_dp) begin
               state_in = S_WAIT;
            end else begin
               case (uw.op)
                  OP_EXPE: begin
                     exp_in   = exponent;
                     cnt_in   = CNT_BITS'(EXP_BITS);
                     complete = 1'b1;
                  end
                  OP_EXPM: begin
                     exp_in   = EXP_BITS'(modulus) - EXP_BITS'(2);
                     cnt_in   = CNT_BITS'(EXP_BITS);
                     complete = 1'b1;
                  end
                  OP_NORM: begin
                     exp_in   = exp_ff << 1;
                     cnt_in   = cnt_ff - 1'b1;
                     complete = exp_ff[EXP_BITS-1];
                  end
                  OP_SHIFT: begin
                     exp_in   = exp_ff << 1;
                     cnt_in   = cnt_ff - 1'b1;
                     complete = 1'b1;
                  end
                  OP_FLAG: begin
                     flag_in  = (mode == MODE_INV);
                     complete = 1'b1;
                  end
                  OP_DONE: begin
                     if (out_free) begin
                        finish   = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  default: complete = 1'b1;
               endcase
            end
         end
         S_WAIT: begin
            if (dp_stat.done) begin
               zf_in    = dp_stat.zero;
               complete = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (complete) begin
         pc_in    = next_pc;
         state_in = S_FETCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         flag_ff  <= 1'b0;
         zf_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         flag_ff  <= flag_in;
         zf_ff    <= zf_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
   end

   assign ctl.dp_start  = (state_ff == S_EXEC) && is_dp;
   assign ctl.dp_op     = uw.op;
   assign ctl.rd_addr_a = uw.sa;
   assign ctl.rd_addr_b = uw.sb;
   assign ctl.wr_en     = (state_ff == S_WAIT) && dp_stat.done;
   assign ctl.wr_addr   = uw.dst;
   assign idle          = (state_ff == S_IDLE);
   assign flag          = flag_ff;

endmodule

### rtl/core/quadratic_extension_field_alu_core.sv
// GF(p^2) arithmetic core (i*i = -1) with the modulus p in a write-only register.
// One request at a time. Each micro step is fetched and then executed; an add-type
// or multiply step also waits for the datapath, where a field multiplication or
// operand reduction runs in the bit-serial modular multiplier, which sets the rate.
// The prologue reduces four operands, which dominates the add-type modes. Multiply
// takes 3 field multiplications and square 2. Inverse takes up to about 2*FIELD_BITS
// field multiplications plus the prologue. Power takes 2 field multiplications for
// a clear and 5 for a set exponent bit after the leading one. A new request is
// taken while the previous result waits in the output register.
// depends on fq2_pkg, fq2_regfile, fq2_datapath, fq2_sequencer
module quadratic_extension_field_alu_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [63:0]  csr_write_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_real, a_imag, b_real, b_imag, exponent
   input  logic [319:0] req_tdata,
   // mode
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_real, result_imag
   output logic [127:0] rsp_tdata,
   // zero_inverse
   output logic [0:0]   rsp_tuser
);
   import fq2_pkg::*;

   logic [DATA_BITS-1:0] prime_ff;
   logic [MODE_BITS-1:0] mode_ff;
   elem_type             ar_ff, ai_ff, br_ff, bi_ff;
   logic [EXP_BITS-1:0]  exp_ff;
   logic                 rsp_valid_ff;
   elem_type             rsp_real_ff, rsp_imag_ff;
   logic                 rsp_flag_ff;

   seq_ctl_type ctl;
   dp_stat_type dp_stat;
   elem_type    modulus;
   elem_type    rd_a, rd_b, dp_res, raw_sel;
   logic        idle, finish, flag, accept, out_free;

   assign modulus    = prime_ff[FIELD_BITS-1:0];
   assign req_tready = idle;
   assign accept     = req_tvalid && idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (ctl.rd_addr_a)
         R_AR:    raw_sel = ar_ff;
         R_AI:    raw_sel = ai_ff;
         R_BR:    raw_sel = br_ff;
         R_BI:    raw_sel = bi_ff;
         default: raw_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff     <= PRIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            prime_ff <= csr_write_data;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_tuser;
         ar_ff   <= req_tdata[FIELD_BITS-1:0];
         ai_ff   <= req_tdata[64 +: FIELD_BITS];
         br_ff   <= req_tdata[128 +: FIELD_BITS];
         bi_ff   <= req_tdata[192 +: FIELD_BITS];
         exp_ff  <= req_tdata[319:256];
      end
      if (finish) begin
         rsp_real_ff <= rd_a;
         rsp_imag_ff <= rd_b;
         rsp_flag_ff <= flag;
      end
   end

   fq2_regfile u_regfile (
      .clock     (clock),
      .wr_en     (ctl.wr_en),
      .wr_addr   (ctl.wr_addr),
      .wr_data   (dp_res),
      .rd_addr_a (ctl.rd_addr_a),
      .rd_addr_b (ctl.rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   fq2_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.dp_start),
      .op      (ctl.dp_op),
      .opa     (rd_a),
      .opb     (rd_b),
      .raw     (raw_sel),
      .modulus (modulus),
      .result  (dp_res),
      .stat    (dp_stat)
   );

   fq2_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .mode     (mode_ff),
      .exponent (exp_ff),
      .modulus  (modulus),
      .dp_stat  (dp_stat),
      .out_free (out_free),
      .ctl      (ctl),
      .idle     (idle),
      .finish   (finish),
      .flag     (flag)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {DATA_BITS'(rsp_imag_ff), DATA_BITS'(rsp_real_ff)};
   assign rsp_tuser[0] = rsp_flag_ff;

`ifndef SYNTHESIS
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending one");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer idle right after a request");
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("zero_inverse with a nonzero result");
`endif

endmodule
